/* rtl/core/sdde_pkg.sv */
// Shared types and constants for the signed decimal digit emitter.
`default_nettype none
package sdde_pkg;

	// Magnitude of a 16-bit two's complement value, -32768 included
	localparam int unsigned MAG_W = 17;
	// Decimal digits needed for the largest magnitude (32768)
	localparam int unsigned MAG_DIGITS = 5;
	// Width of the significant digit count (0..MAG_DIGITS)
	localparam int unsigned NDIG_W = 3;

	// Code-B minus sign
	localparam logic [3:0] MINUS_CODE = 4'hA;

	// Divide by ten as (m * DIV10_MUL) >> DIV10_SHIFT, exact for m below 81920
	localparam logic [15:0] DIV10_MUL = 16'd52429;
	localparam int unsigned DIV10_SHIFT = 19;

	// Word carried down the conversion pipeline
	typedef struct packed {
		logic neg;
		logic [MAG_W-1:0] mag;
		logic [MAG_DIGITS-1:0][3:0] digits;
		logic [NDIG_W-1:0] ndig;
	} conv_t;

endpackage
`default_nettype wire

/* rtl/core/sdde_sign_stage.sv */
// First pipeline stage: split the input word into sign and magnitude.
`default_nettype none
module sdde_sign_stage (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic signed [15:0] in_value,
	output logic out_valid,
	input  wire logic out_ready,
	output sdde_pkg::conv_t out_word
);

	logic valid_s1;
	sdde_pkg::conv_t word_s1;
	sdde_pkg::conv_t nxt;

	// Build magnitude, 0x10000 - raw for a negative word
	always_comb begin
		nxt = '0;
		nxt.neg = in_value[15];
		if (in_value[15]) begin
			nxt.mag = 17'h10000 - {1'b0, in_value};
		end else begin
			nxt.mag = {1'b0, in_value};
		end
	end

	// Advance when the stage is empty or downstream takes it
	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_word = word_s1;

endmodule
`default_nettype wire

/* rtl/core/sdde_digit_stage.sv */
// One pipeline stage: peel the next decimal digit off the magnitude.
`default_nettype none
module sdde_digit_stage #(
	parameter int unsigned STAGE_INDEX = 0
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire sdde_pkg::conv_t in_word,
	output logic out_valid,
	input  wire logic out_ready,
	output sdde_pkg::conv_t out_word
);

	logic valid_s;
	sdde_pkg::conv_t word_s;
	sdde_pkg::conv_t nxt;
	logic [32:0] prod;
	logic [sdde_pkg::MAG_W-1:0] quot;
	logic [sdde_pkg::MAG_W+2:0] quot_x10;
	logic [sdde_pkg::MAG_W-1:0] rem;

	// Divide by ten through the reciprocal, remainder is the digit
	always_comb begin
		prod = 33'(in_word.mag) * 33'(sdde_pkg::DIV10_MUL);
		quot = sdde_pkg::MAG_W'(prod >> sdde_pkg::DIV10_SHIFT);
		quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
		rem = in_word.mag - sdde_pkg::MAG_W'(quot_x10);
		nxt = in_word;
		nxt.mag = quot;
		nxt.digits[STAGE_INDEX] = rem[3:0];
		// A digit is significant while the magnitude left is nonzero, or at stage 0
		if ((in_word.mag != '0) || (STAGE_INDEX == 0)) begin
			nxt.ndig = sdde_pkg::NDIG_W'(STAGE_INDEX + 1);
		end
	end

	assign in_ready = !valid_s || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (in_ready) begin
			valid_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s <= nxt;
		end
	end

	assign out_valid = valid_s;
	assign out_word = word_s;

	// A stored digit is always decimal
	a_digit_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s |-> (word_s.digits[STAGE_INDEX] < 4'd10))
		else $error("digit stage produced a non-decimal digit");

endmodule
`default_nettype wire

/* rtl/core/sdde_emitter.sv */
// Output sequencer: send the digit writes of one word, low digit first.
`default_nettype none
module sdde_emitter #(
	parameter int unsigned DIGIT_COUNT = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire sdde_pkg::conv_t in_word,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [2:0] out_position,
	output logic [3:0] out_code,
	output logic out_last
);

	localparam int unsigned IDX_W = $clog2(DIGIT_COUNT + 1);
	localparam int unsigned CW = (IDX_W > 3) ? IDX_W : 3;
	localparam int unsigned PW = (IDX_W + 1 > 3) ? IDX_W + 1 : 3;

	logic valid_q;
	logic neg_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] total_q;
	logic [sdde_pkg::MAG_DIGITS-1:0][3:0] digits_q;

	logic [CW-1:0] limit_w;
	logic [CW-1:0] ndig_w;
	logic [IDX_W-1:0] cnt_nxt;
	logic [CW-1:0] idx_w;
	logic [PW-1:0] pos_w;
	logic fire;

	// Writes for a word: significant digits capped by the display, plus sign
	always_comb begin
		if (in_word.neg) begin
			limit_w = CW'(DIGIT_COUNT - 1);
		end else begin
			limit_w = CW'(DIGIT_COUNT);
		end
		ndig_w = CW'(in_word.ndig);
		if (ndig_w < limit_w) begin
			cnt_nxt = IDX_W'(ndig_w);
		end else begin
			cnt_nxt = IDX_W'(limit_w);
		end
	end

	assign fire = valid_q && out_ready;
	assign in_ready = !valid_q || (out_ready && out_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Load a new word, or step to the next write
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			neg_q <= in_word.neg;
			digits_q <= in_word.digits;
			cnt_q <= cnt_nxt;
			total_q <= cnt_nxt + IDX_W'(in_word.neg);
			idx_q <= '0;
		end else if (fire) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Select the code of the current write
	always_comb begin
		idx_w = CW'(idx_q);
		pos_w = PW'(idx_q) + PW'(1);
		out_code = '0;
		for (int k = 0; k < sdde_pkg::MAG_DIGITS; k++) begin
			if (idx_w == CW'(k)) begin
				out_code = digits_q[k];
			end
		end
		if (neg_q && (idx_q == cnt_q)) begin
			out_code = sdde_pkg::MINUS_CODE;
		end
	end

	assign out_valid = valid_q;
	assign out_position = pos_w[2:0];
	assign out_last = ((idx_q + 1'b1) == total_q);

	a_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (total_q != '0))
		else $error("word loaded with no writes");

	a_minus_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && neg_q && (idx_q == cnt_q)) |-> out_last)
		else $error("minus sign is not the final write");

	a_word_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !out_last) |=> (valid_q && (idx_q == $past(idx_q) + 1'b1)))
		else $error("word dropped before its final write");

	a_digit_before_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && (idx_q != cnt_q || !neg_q)) |-> (out_code < 4'd10))
		else $error("non-decimal code in a digit write");

endmodule
`default_nettype wire

/* rtl/core/signed_decimal_digit_emitter_unit.sv */
// Top level: signed value in, seven-segment digit writes out.
//
//   channel  handshake                   payload
//   value    value_valid / value_ready   signed_value[15:0]
//   write    write_valid / write_ready   digit_position[2:0], digit_code[3:0], last_write
//
// A value passes a sign stage and five digit stages (one divide by ten each),
// then the emitter register, before its first write appears.
// The single write port then sends one write per cycle while write_ready is high;
// a value takes from 1 to DIGIT_COUNT writes, and that port sets the sustained rate.
// The stages take a new value every cycle; a stalled write holds the stages
// behind it without loss. Reset clears the valid bits only.
`default_nettype none
module signed_decimal_digit_emitter_unit #(
	parameter int unsigned DIGIT_COUNT = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic value_valid,
	output logic value_ready,
	input  wire logic signed [15:0] signed_value,
	output logic write_valid,
	input  wire logic write_ready,
	output logic [2:0] digit_position,
	output logic [3:0] digit_code,
	output logic last_write
);

	localparam int unsigned NST = sdde_pkg::MAG_DIGITS;

	logic [NST:0] stg_valid;
	logic [NST:0] stg_ready;
	sdde_pkg::conv_t stg_word [NST+1];

	// Split sign and magnitude
	sdde_sign_stage u_sign (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(value_valid),
		.in_ready(value_ready),
		.in_value(signed_value),
		.out_valid(stg_valid[0]),
		.out_ready(stg_ready[0]),
		.out_word(stg_word[0])
	);

	// One decimal digit per stage
	for (genvar i = 0; i < NST; i++) begin : g_digit
		sdde_digit_stage #(
			.STAGE_INDEX(i)
		) u_digit (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(stg_valid[i]),
			.in_ready(stg_ready[i]),
			.in_word(stg_word[i]),
			.out_valid(stg_valid[i+1]),
			.out_ready(stg_ready[i+1]),
			.out_word(stg_word[i+1])
		);
	end

	// Sequence the writes of each word
	sdde_emitter #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(stg_valid[NST]),
		.in_ready(stg_ready[NST]),
		.in_word(stg_word[NST]),
		.out_valid(write_valid),
		.out_ready(write_ready),
		.out_position(digit_position),
		.out_code(digit_code),
		.out_last(last_write)
	);

endmodule
`default_nettype wire
